// File: sv/fdec_pkg.sv
// Shared types and constants for the XOR-checked frame decoder.
// No dependencies; fdec_res_if, the decoder and its checker import it.
package fdec_pkg;

  localparam logic [7:0]  StartByte   = 8'hFE;
  localparam logic [15:0] MaxLenReset = 16'd128;

  localparam int unsigned PaddrWidth = 3;
  localparam int unsigned PdataWidth = 32;

  // Register index within the configuration space.
  localparam logic RegMaxLen = 1'b0;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_FRAME   = 2'd1,
    KIND_REJECT  = 2'd2
  } result_kind_e;

  typedef enum logic [6:0] {
    PH_WAIT    = 7'b0000001,
    PH_FUNC_HI = 7'b0000010,
    PH_FUNC_LO = 7'b0000100,
    PH_LEN_HI  = 7'b0001000,
    PH_LEN_LO  = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_CHECK   = 7'b1000000
  } phase_e;

endpackage

// File: sv/fdec_rx_if.sv
// Byte input channel of the frame decoder: valid/ready plus one received byte.
// Depends on nothing.
interface fdec_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: sv/fdec_res_if.sv
// Result channel of the frame decoder: valid/ready plus one result item.
// Depends on fdec_pkg for the result kind type.
interface fdec_res_if
  import fdec_pkg::*;
;
  logic         valid;
  logic         ready;
  result_kind_e result_kind;
  logic [7:0]   payload_byte;
  logic [15:0]  payload_index;
  logic [15:0]  function_code;
  logic [15:0]  payload_length;
  logic         checksum_ok;

  modport source (
    output valid, output result_kind, output payload_byte, output payload_index,
    output function_code, output payload_length, output checksum_ok, input ready
  );
  modport sink (
    input valid, input result_kind, input payload_byte, input payload_index,
    input function_code, input payload_length, input checksum_ok, output ready
  );
endinterface

// File: sv/xor_checked_frame_decoder.sv
// Frame decoder: start byte 0xFE, 16-bit function, 16-bit length, payload, XOR checksum.
// Depends on fdec_pkg, fdec_rx_if and fdec_res_if.
//
// The decoder takes one received byte per clock cycle while not stalled. Each
// byte updates the receive phase, header fields and running XOR in a single
// register stage, and any result it causes appears on the result channel in
// the cycle after the byte is accepted. The result register is the only buffer:
// a new byte is taken in the same cycle that a waiting result is taken, so the
// sustained rate is one byte per cycle unless the result side stalls. Payload
// bytes give one result each, the checksum byte gives the frame result, and an
// over-long length gives a rejection; header bytes and bytes between frames
// give none. The maximum length register is at APB word address 0.
module xor_checked_frame_decoder
  import fdec_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fdec_rx_if.sink               rx_i,
  fdec_res_if.source            res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [PdataWidth-1:0] pwdata,
  output logic [PdataWidth-1:0] prdata,
  output logic                  pready
);

  phase_e       phase_q, phase_d;
  logic [15:0]  func_q, func_d;
  logic [15:0]  len_q, len_d;
  logic [15:0]  cnt_q, cnt_d;
  logic [7:0]   csum_q, csum_d;
  logic [15:0]  max_len_q;

  logic         res_valid_q;
  result_kind_e kind_q, kind_d;
  logic [7:0]   byte_q, byte_d;
  logic [15:0]  idx_q, idx_d;
  logic [15:0]  res_func_q;
  logic [15:0]  res_len_q;
  logic         ok_q, ok_d;

  logic         accept;
  logic         emit;
  logic [7:0]   c;
  logic [16:0]  cnt_inc;
  logic         reg_sel;

  assign c       = rx_i.rx_byte;
  assign rx_i.ready = !res_valid_q || res_o.ready;
  assign accept  = rx_i.valid && rx_i.ready;
  assign cnt_inc = {1'b0, cnt_q} + 17'd1;

  always_comb begin
    phase_d = phase_q;
    func_d  = func_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    csum_d  = csum_q ^ c;
    emit    = 1'b0;
    kind_d  = KIND_PAYLOAD;
    byte_d  = '0;
    idx_d   = '0;
    ok_d    = 1'b0;
    unique case (phase_q)
      PH_FUNC_HI: begin
        func_d  = {c, 8'h00};
        phase_d = PH_FUNC_LO;
      end
      PH_FUNC_LO: begin
        func_d  = {func_q[15:8], c};
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_d   = {c, 8'h00};
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_d = {len_q[15:8], c};
        cnt_d = '0;
        if (len_d > max_len_q) begin
          phase_d = PH_WAIT;
          emit    = 1'b1;
          kind_d  = KIND_REJECT;
        end else if (len_d == '0) begin
          phase_d = PH_CHECK;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        cnt_d  = cnt_inc[15:0];
        emit   = 1'b1;
        kind_d = KIND_PAYLOAD;
        byte_d = c;
        idx_d  = cnt_q;
        if (cnt_inc >= {1'b0, len_q}) begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        phase_d = PH_WAIT;
        emit    = 1'b1;
        kind_d  = KIND_FRAME;
        ok_d    = (c == csum_q);
      end
      default: begin
        // Waiting for a start byte; anything else is dropped.
        csum_d = csum_q;
        if (c == StartByte) begin
          csum_d  = StartByte;
          phase_d = PH_FUNC_HI;
        end else begin
          phase_d = PH_WAIT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      func_q  <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      csum_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      func_q  <= func_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      csum_q  <= csum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept && emit) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      kind_q     <= kind_d;
      byte_q     <= byte_d;
      idx_q      <= idx_d;
      res_func_q <= func_d;
      res_len_q  <= len_d;
      ok_q       <= ok_d;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.result_kind    = kind_q;
  assign res_o.payload_byte   = byte_q;
  assign res_o.payload_index  = idx_q;
  assign res_o.function_code  = res_func_q;
  assign res_o.payload_length = res_len_q;
  assign res_o.checksum_ok    = ok_q;

  // Configuration port: one register, word address taken from paddr[2].
  assign reg_sel = (paddr[2] == RegMaxLen);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(PdataWidth-16){1'b0}}, max_len_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (psel && penable && pwrite && reg_sel) begin
      max_len_q <= pwdata[15:0];
    end
  end

endmodule

// File: sv/fdec_checker.sv
// Port-level checks for the frame decoder, attached by the bind at the end.
// Depends on fdec_pkg and on xor_checked_frame_decoder.
module fdec_checker
  import fdec_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         rx_valid,
  input logic         rx_ready,
  input logic         res_valid,
  input logic         res_ready,
  input result_kind_e res_kind,
  input logic [7:0]   res_byte,
  input logic [15:0]  res_index,
  input logic [15:0]  res_length,
  input logic         res_ok
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // A new result only follows an accepted byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid) |-> $past(rx_valid && rx_ready))
    else $error("result without an accepted item");

  // A payload byte lies inside the announced length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_kind == KIND_PAYLOAD |-> res_index < res_length)
    else $error("payload index beyond frame length");

  // Frame and rejection results carry zeroed payload fields; only a frame result may set the checksum flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_kind != KIND_PAYLOAD |-> res_byte == '0 && res_index == '0)
    else $error("payload fields set on a frame or rejection result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_kind != KIND_FRAME |-> !res_ok)
    else $error("checksum flag set outside a frame result");

endmodule

bind xor_checked_frame_decoder fdec_checker u_fdec_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .rx_valid   (rx_i.valid),
  .rx_ready   (rx_i.ready),
  .res_valid  (res_o.valid),
  .res_ready  (res_o.ready),
  .res_kind   (res_o.result_kind),
  .res_byte   (res_o.payload_byte),
  .res_index  (res_o.payload_index),
  .res_length (res_o.payload_length),
  .res_ok     (res_o.checksum_ok)
);
